// ----- src/lbbt_pkg.sv -----
// Shared types and constants of the block buffer tag engine.
package lbbt_pkg;

   localparam int SLOTS_DEF  = 64;
   localparam int TAG_W      = 32;
   localparam int REF_W      = 8;
   localparam int SLOT_IDX_W = 6;
   localparam int STATUS_W   = 3;
   localparam int SLOT_DW    = TAG_W + REF_W;

   localparam logic [TAG_W-1:0] TAG_UNUSED = {TAG_W{1'b1}};
   localparam logic [REF_W-1:0] REFS_MAX   = {REF_W{1'b1}};

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADREL   = 3'd4;

   typedef struct packed {
      logic                  operation;
      logic [TAG_W-1:0]      block_number;
      logic [SLOT_IDX_W-1:0] release_slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [STATUS_W-1:0]   status;
      logic [REF_W-1:0]      ref_count_after;
   } rsp_type;

endpackage

// ----- src/lbbt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lbbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/lru_block_buffer_tags.sv -----
// Top level of the block buffer tag and replacement engine.
//
// Request channel: an item is taken on a rising edge with start high and busy
// low. An acquire looks up block_number; a release hands back release_slot.
// Response channel: rsp_strobe is high for one cycle with rsp_data; the
// receiver cannot stall it, so nothing is ever held back.
// Sequence: the response shows in the cycle after the deciding step. An
// acquire reads the list head, walks from the most recent end one linked
// slot per cycle for a tag match, then on a miss walks from the least recent
// end one slot per cycle for a free slot; a new request is taken only once
// the response is out. Each walk step is one read of the tag memory and the
// link memory, both with registered read data. A release out of range
// answers without going busy; a release checks its count and, when the
// count drops to zero, relinks the slot at the most recent end through the
// read-modify-write states S_MVO, S_MVN, S_MVH, S_MVF and S_MVT on the link
// memory.
// Reset: synchronous; per-entry valid bits make every slot read as unused
// with count zero and the list as slot 0 (newest) through SLOTS-1 (oldest),
// with no clearing pass.
module lru_block_buffer_tags #(
   parameter int SLOTS = lbbt_pkg::SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  lbbt_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output lbbt_pkg::rsp_type rsp_data
);

   import lbbt_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam int LINK_DW = 2 * LINK_W;
   localparam logic [LINK_W-1:0] HEAD = LINK_W'(SLOTS);
   localparam logic [LINK_W-1:0] ONE  = LINK_W'(1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_AHEAD = 10'b0000000010,
      S_HWALK = 10'b0000000100,
      S_MWALK = 10'b0000001000,
      S_RCHK  = 10'b0000010000,
      S_MVO   = 10'b0000100000,
      S_MVN   = 10'b0001000000,
      S_MVH   = 10'b0010000000,
      S_MVF   = 10'b0100000000,
      S_MVT   = 10'b1000000000
   } state_type;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] cnt_ff, cnt_in;
   logic [LINK_W-1:0] head_newer_ff, head_newer_in;
   logic [LINK_W-1:0] o_ff, o_in;
   logic [LINK_W-1:0] n_ff, n_in;
   logic [LINK_W-1:0] first_ff, first_in;

   logic [SLOTS-1:0]  slot_vld_ff;
   logic [SLOTS:0]    link_vld_ff;
   logic              slot_rvld_ff;
   logic              link_rvld_ff;
   logic [LINK_W-1:0] link_raddr_ff;
   logic              fwd_ff;
   logic [LINK_DW-1:0] fwd_data_ff;

   logic               slot_we;
   logic [SLOT_W-1:0]  slot_wr_addr;
   logic [SLOT_DW-1:0] slot_wr_data;
   logic [SLOT_W-1:0]  slot_rd_addr;
   logic [SLOT_DW-1:0] slot_rd_data;
   logic               link_we;
   logic [LINK_W-1:0]  link_wr_addr;
   logic [LINK_DW-1:0] link_wr_data;
   logic [LINK_W-1:0]  link_rd_addr;
   logic [LINK_DW-1:0] link_rd_data;

   logic [LINK_DW-1:0] link_rst;
   logic [LINK_DW-1:0] link_q;
   logic [LINK_W-1:0]  q_older, q_newer;
   logic [LINK_W-1:0]  nb_older, nb_newer;
   logic [TAG_W-1:0]   q_tag;
   logic [REF_W-1:0]   q_refs;
   logic [REF_W-1:0]   refs_up, refs_down;
   logic               go_miss;
   logic [LINK_W-1:0]  miss_first;

   function automatic logic [LINK_W-1:0] safe_link(input logic [LINK_W-1:0] v);
      return (v > HEAD) ? HEAD : v;
   endfunction

   lbbt_ram #(
      .WIDTH (SLOT_DW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   lbbt_ram #(
      .WIDTH (LINK_DW),
      .DEPTH (SLOTS + 1)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   // reset-order links of the entry just read: {older, newer}
   always_comb begin
      if (link_raddr_ff == HEAD) begin
         link_rst = {LINK_W'(0), LINK_W'(SLOTS - 1)};
      end else if (link_raddr_ff == '0) begin
         link_rst = {ONE, HEAD};
      end else begin
         link_rst = {link_raddr_ff + ONE, link_raddr_ff - ONE};
      end
   end

   // bypass the write made on the same edge as the read
   assign link_q   = fwd_ff ? fwd_data_ff : (link_rvld_ff ? link_rd_data : link_rst);
   assign q_older  = link_q[LINK_DW-1:LINK_W];
   assign q_newer  = link_q[LINK_W-1:0];
   assign nb_older = safe_link(q_older);
   assign nb_newer = safe_link(q_newer);
   assign q_tag    = slot_rvld_ff ? slot_rd_data[SLOT_DW-1:REF_W] : TAG_UNUSED;
   assign q_refs   = slot_rvld_ff ? slot_rd_data[REF_W-1:0] : '0;
   assign refs_up  = (q_refs == REFS_MAX) ? q_refs : q_refs + 8'd1;
   assign refs_down = q_refs - 8'd1;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      head_newer_in = head_newer_ff;
      o_in          = o_ff;
      n_in          = n_ff;
      first_in      = first_ff;
      slot_we       = 1'b0;
      slot_wr_addr  = cur_ff[SLOT_W-1:0];
      slot_wr_data  = {q_tag, q_refs};
      slot_rd_addr  = cur_ff[SLOT_W-1:0];
      link_we       = 1'b0;
      link_wr_addr  = cur_ff;
      link_wr_data  = link_q;
      link_rd_addr  = HEAD;
      go_miss       = 1'b0;
      miss_first    = head_newer_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.operation == OP_ACQUIRE) begin
                  link_rd_addr = HEAD;
                  state_in     = S_AHEAD;
               end else if (int'(req_data.release_slot) >= SLOTS) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{slot_index: req_data.release_slot, status: ST_BADREL,
                             ref_count_after: '0};
               end else begin
                  cur_in       = LINK_W'(req_data.release_slot);
                  slot_rd_addr = SLOT_W'(req_data.release_slot);
                  link_rd_addr = LINK_W'(req_data.release_slot);
                  state_in     = S_RCHK;
               end
            end
         end
         S_AHEAD: begin
            head_newer_in = nb_newer;
            if (nb_older == HEAD) begin
               go_miss    = 1'b1;
               miss_first = nb_newer;
            end else begin
               cur_in       = nb_older;
               cnt_in       = ONE;
               slot_rd_addr = nb_older[SLOT_W-1:0];
               link_rd_addr = nb_older;
               state_in     = S_HWALK;
            end
         end
         S_HWALK: begin
            if (q_tag == req_ff.block_number) begin
               slot_we       = 1'b1;
               slot_wr_data  = {q_tag, refs_up};
               rsp_strobe_in = 1'b1;
               rsp_in = '{slot_index: SLOT_IDX_W'(cur_ff), status: ST_HIT,
                          ref_count_after: refs_up};
               state_in      = S_IDLE;
            end else if (nb_older == HEAD || cnt_ff == HEAD) begin
               go_miss = 1'b1;
            end else begin
               cur_in       = nb_older;
               cnt_in       = cnt_ff + ONE;
               slot_rd_addr = nb_older[SLOT_W-1:0];
               link_rd_addr = nb_older;
            end
         end
         S_MWALK: begin
            if (q_refs == '0) begin
               slot_we       = 1'b1;
               slot_wr_data  = {req_ff.block_number, 8'd1};
               rsp_strobe_in = 1'b1;
               rsp_in = '{slot_index: SLOT_IDX_W'(cur_ff), status: ST_MISS,
                          ref_count_after: 8'd1};
               state_in      = S_IDLE;
            end else if (nb_newer == HEAD || cnt_ff == HEAD) begin
               rsp_strobe_in = 1'b1;
               rsp_in   = '{slot_index: '0, status: ST_NOFREE, ref_count_after: '0};
               state_in = S_IDLE;
            end else begin
               cur_in       = nb_newer;
               cnt_in       = cnt_ff + ONE;
               slot_rd_addr = nb_newer[SLOT_W-1:0];
               link_rd_addr = nb_newer;
            end
         end
         S_RCHK: begin
            rsp_strobe_in = 1'b1;
            if (q_refs == '0) begin
               rsp_in = '{slot_index: req_ff.release_slot, status: ST_BADREL,
                          ref_count_after: '0};
               state_in = S_IDLE;
            end else begin
               slot_we      = 1'b1;
               slot_wr_data = {q_tag, refs_down};
               rsp_in = '{slot_index: req_ff.release_slot, status: ST_RELEASED,
                          ref_count_after: refs_down};
               if (refs_down == '0) begin
                  o_in         = nb_older;
                  n_in         = nb_newer;
                  link_rd_addr = nb_older;
                  state_in     = S_MVO;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MVO: begin
            // unlink: newer[o] = n
            link_we      = 1'b1;
            link_wr_addr = o_ff;
            link_wr_data = {q_older, n_ff};
            link_rd_addr = n_ff;
            state_in     = S_MVN;
         end
         S_MVN: begin
            // unlink: older[n] = o
            link_we      = 1'b1;
            link_wr_addr = n_ff;
            link_wr_data = {o_ff, q_newer};
            link_rd_addr = HEAD;
            state_in     = S_MVH;
         end
         S_MVH: begin
            first_in     = nb_older;
            link_we      = 1'b1;
            link_wr_addr = cur_ff;
            link_wr_data = {nb_older, HEAD};
            link_rd_addr = nb_older;
            state_in     = S_MVF;
         end
         S_MVF: begin
            link_we      = 1'b1;
            link_wr_addr = first_ff;
            link_wr_data = {q_older, cur_ff};
            link_rd_addr = HEAD;
            state_in     = S_MVT;
         end
         S_MVT: begin
            link_we      = 1'b1;
            link_wr_addr = HEAD;
            link_wr_data = {cur_ff, q_newer};
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // start the walk for a free slot from the least recent end, or answer no free slot when the list is empty
      if (go_miss) begin
         if (miss_first == HEAD) begin
            rsp_strobe_in = 1'b1;
            rsp_in   = '{slot_index: '0, status: ST_NOFREE, ref_count_after: '0};
            state_in = S_IDLE;
         end else begin
            cur_in       = miss_first;
            cnt_in       = ONE;
            slot_rd_addr = miss_first[SLOT_W-1:0];
            link_rd_addr = miss_first;
            state_in     = S_MWALK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         slot_vld_ff   <= '0;
         link_vld_ff   <= '0;
         fwd_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (slot_we) begin
            slot_vld_ff[slot_wr_addr] <= 1'b1;
         end
         if (link_we) begin
            link_vld_ff[link_wr_addr] <= 1'b1;
         end
         fwd_ff <= link_we && (link_wr_addr == link_rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      head_newer_ff <= head_newer_in;
      o_ff          <= o_in;
      n_ff          <= n_in;
      first_ff      <= first_in;
      fwd_data_ff   <= link_wr_data;
      link_raddr_ff <= link_rd_addr;
      slot_rvld_ff  <= slot_vld_ff[slot_rd_addr];
      link_rvld_ff  <= link_vld_ff[link_rd_addr];
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // a tag or count update always comes with its response beat
   a_slot_write_answers: assert property (@(posedge clock) disable iff (reset)
      slot_we |=> rsp_strobe_ff)
      else $error("slot memory written without a response beat");

   // list walks only read the link memory
   a_walk_no_link_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AHEAD || state_ff == S_HWALK || state_ff == S_MWALK) |-> !link_we)
      else $error("link memory written during a walk");

   a_miss_count_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status == ST_MISS) |-> rsp_ff.ref_count_after == 8'd1)
      else $error("miss response with count other than one");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HWALK || state_ff == S_MWALK) |-> (cnt_ff != '0 && cnt_ff <= HEAD))
      else $error("walk step count out of range");

   a_no_beat_on_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_strobe_ff)
      else $error("response beat on the first busy cycle");

endmodule
